// ===== rtl/button_packet_motor_duty_decoder_defines.svh =====
// Assertion macros used by the button packet decoder top-level RTL.
`ifndef BUTTON_PACKET_MOTOR_DUTY_DECODER_DEFINES_SVH
`define BUTTON_PACKET_MOTOR_DUTY_DECODER_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define BPMD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define BPMD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bpmd_pkg.sv =====
// Types and constants of the button packet decoder.
package bpmd_pkg;

    localparam logic [7:0] CH_START = 8'h21;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_FIVE  = 8'h35;
    localparam logic [7:0] CH_SIX   = 8'h36;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_EIGHT = 8'h38;

    // Duties in 256ths: 0.5, 0.2 and 0.95.
    localparam logic [7:0] FORWARD_DUTY_RST   = 8'd128;
    localparam logic [7:0] TURN_SLOW_DUTY_RST = 8'd51;
    localparam logic [7:0] TURN_FAST_DUTY_RST = 8'd243;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int RESULT_W    = 42;
    localparam int OUT_TDATA_W = 48;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FORWARD   = 2'd0,
        CFG_TURN_SLOW = 2'd1,
        CFG_TURN_FAST = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_MARK_B = 3'd1,
        PH_BUTTON = 3'd2,
        PH_HIT    = 3'd3,
        PH_CHECK  = 3'd4
    } t_phase;

    typedef struct packed {
        logic [7:0] forward_duty;
        logic [7:0] turn_slow_duty;
        logic [7:0] turn_fast_duty;
    } t_cfg;

    // Last member sits in the lowest bits.
    typedef struct packed {
        logic [7:0] duty_four;
        logic [7:0] duty_three;
        logic [7:0] duty_two;
        logic [7:0] duty_one;
        logic       led_on;
        logic       pressed;
        logic [7:0] button_code;
    } t_result;

endpackage

// ===== rtl/bpmd_parser.sv =====
// Packet parser state machine with held button, hit and motor duties.
module bpmd_parser
    import bpmd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  t_cfg       i_cfg,
    output logic       o_result_valid,
    output t_result    o_result
);

    t_phase           r_phase, n_phase;
    logic [7:0]       r_button, n_button;
    logic [7:0]       r_hit, n_hit;
    logic [3:0][7:0]  r_duty, n_duty;
    logic [7:0]       w_sum;
    logic             w_hit;

    assign w_sum = 8'(CH_START + CH_B + r_button + r_hit);
    assign w_hit = (r_hit == CH_ONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_START;
            r_button <= '0;
            r_hit    <= '0;
            r_duty   <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_button <= n_button;
            r_hit    <= n_hit;
            r_duty   <= n_duty;
        end
    end

    always_comb begin
        n_phase        = r_phase;
        n_button       = r_button;
        n_hit          = r_hit;
        n_duty         = r_duty;
        o_result_valid = 1'b0;
        unique case (r_phase)
            PH_MARK_B: begin
                n_phase = (i_byte == CH_B) ? PH_BUTTON : PH_START;
            end
            PH_BUTTON: begin
                n_button = i_byte;
                n_phase  = PH_HIT;
            end
            PH_HIT: begin
                n_hit   = i_byte;
                n_phase = PH_CHECK;
            end
            PH_CHECK: begin
                n_phase = PH_START;
                if (i_byte == ~w_sum) begin
                    o_result_valid = 1'b1;
                    unique case (r_button)
                        CH_FIVE: begin
                            n_duty = w_hit ? {4{i_cfg.forward_duty}} : '0;
                        end
                        CH_SIX: begin
                            n_duty = '0;
                        end
                        // motors one and two sit in the low bytes
                        CH_SEVEN: begin
                            n_duty = w_hit ? {{2{i_cfg.turn_fast_duty}},
                                              {2{i_cfg.turn_slow_duty}}} : '0;
                        end
                        CH_EIGHT: begin
                            n_duty = w_hit ? {{2{i_cfg.turn_slow_duty}},
                                              {2{i_cfg.turn_fast_duty}}} : '0;
                        end
                        default: begin
                            n_duty = r_duty;
                        end
                    endcase
                end
            end
            default: begin
                n_phase = (i_byte == CH_START) ? PH_MARK_B : PH_START;
            end
        endcase
    end

    assign o_result.button_code = r_button;
    assign o_result.pressed     = w_hit;
    assign o_result.led_on      = (r_button != CH_ZERO);
    assign o_result.duty_one    = n_duty[0];
    assign o_result.duty_two    = n_duty[1];
    assign o_result.duty_three  = n_duty[2];
    assign o_result.duty_four   = n_duty[3];

endmodule

// ===== rtl/button_packet_motor_duty_decoder.sv =====
// Button packet decoder: serial bytes in, checked packets with motor duties out.
//
// Usage:
//   s_axis carries one received serial byte per word in tdata[7:0].
//   m_axis carries one word per packet that passes its checksum:
//   '!', 'B', button code, hit byte, NOT of the 8-bit sum of the first four.
//   i_cfg_we/i_cfg_index/i_cfg_data write forward, slow-turn and fast-turn
//   duties (index 0, 1, 2); write only while no byte is in flight.
// Timing:
//   One byte is taken every cycle unless m_axis stalls. A byte lands in the
//   input register, the parser decodes it against its phase and the result
//   register holds the packet word: the checksum byte passes through the input
//   register and then the result register before the word is valid on m_axis.
//   The single parser pass per input register sets the rate of one byte a cycle when m_axis does not stall.
// Reset: parser waits for '!', held bytes and all duties clear to zero,
//   configuration returns to 128, 51 and 243.
// Stall: a word waiting on m_axis holds; one more byte is still taken into
//   the input register, then s_axis_tready drops until the word is taken.
`include "button_packet_motor_duty_decoder_defines.svh"

module button_packet_motor_duty_decoder
    import bpmd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // [7:0] rx_byte
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [7:0] button_code, [8] pressed, [9] led_on, [17:10] duty_one,
    // [25:18] duty_two, [33:26] duty_three, [41:34] duty_four, [47:42] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg       r_cfg;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    logic       w_advance;
    logic       w_res_valid;
    t_result    w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.forward_duty   <= FORWARD_DUTY_RST;
            r_cfg.turn_slow_duty <= TURN_SLOW_DUTY_RST;
            r_cfg.turn_fast_duty <= TURN_FAST_DUTY_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FORWARD:   r_cfg.forward_duty   <= i_cfg_data;
                CFG_TURN_SLOW: r_cfg.turn_slow_duty <= i_cfg_data;
                CFG_TURN_FAST: r_cfg.turn_fast_duty <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Advance the input word whenever the result register can take a word.
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    bpmd_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_advance),
        .i_byte         (r_in_byte),
        .i_cfg          (r_cfg),
        .o_result_valid (w_res_valid),
        .o_result       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_TDATA_W - RESULT_W)'(0), r_out};

    `BPMD_ASSERT_NOW(a_ready_low_only_when_full, i_clk, i_rst_n,
        !s_axis_tready, r_in_valid && r_out_valid && !m_axis_tready,
        "input stalled while the pipeline has room")
    `BPMD_ASSERT_NEXT(a_stalled_byte_held, i_clk, i_rst_n,
        r_in_valid && !w_advance, r_in_valid && $stable(r_in_byte),
        "byte in input register lost during a stall")
    `BPMD_ASSERT_NOW(a_led_matches_button, i_clk, i_rst_n,
        r_out_valid, r_out.led_on == (r_out.button_code != CH_ZERO),
        "led bit disagrees with button code")
    `BPMD_ASSERT_NOW(a_release_stops_motors, i_clk, i_rst_n,
        r_out_valid && !r_out.pressed && (r_out.button_code == CH_FIVE ||
        r_out.button_code == CH_SIX || r_out.button_code == CH_SEVEN ||
        r_out.button_code == CH_EIGHT),
        r_out.duty_one == 8'd0 && r_out.duty_two == 8'd0 &&
        r_out.duty_three == 8'd0 && r_out.duty_four == 8'd0,
        "motors left running after a release")

endmodule
